FILE: hw/rtl/gait_aware_velocity_slew_limiter_assert.svh
// Assertion macros for the velocity slew limiter.
// Needs nothing but a clock and an active-low reset in the including scope.
`ifndef GAIT_AWARE_VELOCITY_SLEW_LIMITER_ASSERT_SVH
`define GAIT_AWARE_VELOCITY_SLEW_LIMITER_ASSERT_SVH

// same-cycle implication
`define GAVSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GAVSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gavsl_pkg.sv
// Shared types and constants for the velocity slew limiter.
// No dependencies; used by the interfaces, the axis unit and the top level.
package gavsl_pkg;

	localparam int VEL_WIDTH = 16;
	localparam int MAG_WIDTH = VEL_WIDTH - 1;
	localparam int LEG_COUNT = 4;
	localparam int CFG_IDX_WIDTH = 3;

	localparam logic signed [VEL_WIDTH-1:0] VEL_MOST_NEG = {1'b1, {MAG_WIDTH{1'b0}}};
	localparam logic [MAG_WIDTH-1:0] MAG_ALL_ONES = {MAG_WIDTH{1'b1}};
	localparam logic [LEG_COUNT-1:0] ALL_STANCE = {LEG_COUNT{1'b1}};

	typedef enum logic {
		OP_CMD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_LIMIT_X      = 3'd0,
		REG_LIMIT_Y      = 3'd1,
		REG_LIMIT_YAW    = 3'd2,
		REG_LINEAR_STEP  = 3'd3,
		REG_ANGULAR_STEP = 3'd4
	} reg_idx_t;

	// per-axis results: clamped command, slewed next velocity and over-limit flag
	typedef struct packed {
		logic signed [VEL_WIDTH-1:0] clamped;
		logic signed [VEL_WIDTH-1:0] next;
		logic                        over;
	} axis_res_t;

endpackage

FILE: hw/rtl/gavsl_if.sv
// Valid/ready channel interfaces for the velocity slew limiter.
// Depends on gavsl_pkg for field widths.
interface gavsl_in_if
	import gavsl_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic signed [VEL_WIDTH-1:0] cmd_x;
	logic signed [VEL_WIDTH-1:0] cmd_y;
	logic signed [VEL_WIDTH-1:0] cmd_yaw;
	logic [LEG_COUNT-1:0]        stance_bits;

	modport source (output valid, op, cmd_x, cmd_y, cmd_yaw, stance_bits, input ready);
	modport sink (input valid, op, cmd_x, cmd_y, cmd_yaw, stance_bits, output ready);
endinterface

interface gavsl_out_if
	import gavsl_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic signed [VEL_WIDTH-1:0] vel_x;
	logic signed [VEL_WIDTH-1:0] vel_y;
	logic signed [VEL_WIDTH-1:0] vel_yaw;
	logic                        over_limit;
	logic                        stop_held;
	logic                        touched_down;

	modport source (output valid, vel_x, vel_y, vel_yaw, over_limit, stop_held, touched_down,
		input ready);
	modport sink (input valid, vel_x, vel_y, vel_yaw, over_limit, stop_held, touched_down,
		output ready);
endinterface

FILE: hw/rtl/gait_aware_velocity_slew_limiter.sv
// Channel | dir | word
// --------+-----+---------------------------------------------------------
// in_ch   | in  | op, cmd_x, cmd_y, cmd_yaw, stance_bits
// out_ch  | out | vel_x, vel_y, vel_yaw, over_limit, stop_held, touched_down
// cfg_*   | in  | write enable, register index, 15-bit data
// One word per clock while out_ch is not stalled: input register, one pass of clamp/slew
// logic, result register. State updates as a word moves from the input register to the
// result register.
// A stalled result register holds the input register; in_ch.ready drops only when both
// are full and out_ch is stalled.
// arst_n clears state, limits to full scale and steps to zero.
// Depends on gavsl_pkg, gavsl_if and gavsl_axis.
`include "gait_aware_velocity_slew_limiter_assert.svh"

module gait_aware_velocity_slew_limiter
	import gavsl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_idx,
	input  logic [MAG_WIDTH-1:0]     cfg_wdata,
	gavsl_in_if.sink                 in_ch,
	gavsl_out_if.source              out_ch
);

	// configuration
	logic [MAG_WIDTH-1:0] lim_x_q, lim_y_q, lim_yaw_q, lin_step_q, ang_step_q;

	// block state
	logic signed [VEL_WIDTH-1:0] cur_x_q, cur_y_q, cur_yaw_q;
	logic signed [VEL_WIDTH-1:0] tgt_x_q, tgt_y_q, tgt_yaw_q;
	logic [LEG_COUNT-1:0]        prior_stance_q;
	logic                        td_seen_q;

	// input register
	logic                        valid_s1;
	logic                        op_s1;
	logic signed [VEL_WIDTH-1:0] cmd_x_s1, cmd_y_s1, cmd_yaw_s1;
	logic [LEG_COUNT-1:0]        stance_s1;

	// result register
	logic                        valid_s2;
	logic signed [VEL_WIDTH-1:0] vel_x_s2, vel_y_s2, vel_yaw_s2;
	logic                        over_s2, held_s2, td_s2;

	axis_res_t res_x, res_y, res_yaw;
	logic      adv, is_tick, moving, stopping, footing_ok, hold, edge_det;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q    <= MAG_ALL_ONES;
			lim_y_q    <= MAG_ALL_ONES;
			lim_yaw_q  <= MAG_ALL_ONES;
			lin_step_q <= '0;
			ang_step_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_LIMIT_X:      lim_x_q    <= cfg_wdata;
				REG_LIMIT_Y:      lim_y_q    <= cfg_wdata;
				REG_LIMIT_YAW:    lim_yaw_q  <= cfg_wdata;
				REG_LINEAR_STEP:  lin_step_q <= cfg_wdata;
				REG_ANGULAR_STEP: ang_step_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1      <= in_ch.op;
			cmd_x_s1   <= in_ch.cmd_x;
			cmd_y_s1   <= in_ch.cmd_y;
			cmd_yaw_s1 <= in_ch.cmd_yaw;
			stance_s1  <= in_ch.stance_bits;
		end
	end

	gavsl_axis u_axis_x (
		.cmd(cmd_x_s1), .limit(lim_x_q), .cur(cur_x_q), .tgt(tgt_x_q),
		.step(lin_step_q), .res(res_x)
	);
	gavsl_axis u_axis_y (
		.cmd(cmd_y_s1), .limit(lim_y_q), .cur(cur_y_q), .tgt(tgt_y_q),
		.step(lin_step_q), .res(res_y)
	);
	gavsl_axis u_axis_yaw (
		.cmd(cmd_yaw_s1), .limit(lim_yaw_q), .cur(cur_yaw_q), .tgt(tgt_yaw_q),
		.step(ang_step_q), .res(res_yaw)
	);

	assign is_tick    = (op_s1 == OP_TICK);
	assign moving     = (cur_x_q != '0) || (cur_y_q != '0) || (cur_yaw_q != '0);
	assign stopping   = (res_x.next == '0) && (res_y.next == '0) && (res_yaw.next == '0);
	assign footing_ok = td_seen_q || (prior_stance_q == ALL_STANCE);
	// a stop is held until a foot lands or all legs were in stance at the prior tick
	assign hold       = moving && stopping && !footing_ok;
	assign edge_det   = |(stance_s1 & ~prior_stance_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			cur_yaw_q      <= '0;
			tgt_x_q        <= '0;
			tgt_y_q        <= '0;
			tgt_yaw_q      <= '0;
			prior_stance_q <= '0;
			td_seen_q      <= 1'b0;
		end else if (adv) begin
			if (is_tick) begin
				if (!hold) begin
					cur_x_q   <= res_x.next;
					cur_y_q   <= res_y.next;
					cur_yaw_q <= res_yaw.next;
				end
				prior_stance_q <= stance_s1;
				td_seen_q      <= edge_det;
			end else begin
				tgt_x_q   <= res_x.clamped;
				tgt_y_q   <= res_y.clamped;
				tgt_yaw_q <= res_yaw.clamped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_tick && !hold) begin
				vel_x_s2   <= res_x.next;
				vel_y_s2   <= res_y.next;
				vel_yaw_s2 <= res_yaw.next;
			end else begin
				vel_x_s2   <= cur_x_q;
				vel_y_s2   <= cur_y_q;
				vel_yaw_s2 <= cur_yaw_q;
			end
			over_s2 <= !is_tick && (res_x.over || res_y.over || res_yaw.over);
			held_s2 <= is_tick && hold;
			td_s2   <= is_tick && edge_det;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.vel_x        = vel_x_s2;
	assign out_ch.vel_y        = vel_y_s2;
	assign out_ch.vel_yaw      = vel_yaw_s2;
	assign out_ch.over_limit   = over_s2;
	assign out_ch.stop_held    = held_s2;
	assign out_ch.touched_down = td_s2;

	`GAVSL_ASSERT_NEXT(a_hold_keeps_vel, clk, arst_n, adv && is_tick && hold,
		$stable(cur_x_q) && $stable(cur_y_q) && $stable(cur_yaw_q), "held tick moved velocity")
	`GAVSL_ASSERT_NEXT(a_td_matches, clk, arst_n, adv && is_tick,
		td_seen_q == td_s2, "touchdown flag and result disagree")
	`GAVSL_ASSERT_NOW(a_flag_groups, clk, arst_n, valid_s2,
		!(over_s2 && (held_s2 || td_s2)), "command and tick flags set together")
	`GAVSL_ASSERT_NOW(a_vel_range, clk, arst_n, 1'b1,
		cur_x_q != VEL_MOST_NEG && cur_y_q != VEL_MOST_NEG && cur_yaw_q != VEL_MOST_NEG,
		"velocity reached most negative code")
	`GAVSL_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv,
		valid_s1, "input register lost a word")

endmodule

FILE: hw/rtl/gavsl_axis.sv
// One velocity axis: clamp of a command to +/-limit and one slew step of the current
// value toward the target, landing on it when within a step or when step is zero. Depends on gavsl_pkg.
module gavsl_axis
	import gavsl_pkg::*;
(
	input  logic signed [VEL_WIDTH-1:0] cmd,
	input  logic [MAG_WIDTH-1:0]        limit,
	input  logic signed [VEL_WIDTH-1:0] cur,
	input  logic signed [VEL_WIDTH-1:0] tgt,
	input  logic [MAG_WIDTH-1:0]        step,
	output axis_res_t                   res
);

	logic signed [VEL_WIDTH:0] cmd_w;
	logic signed [VEL_WIDTH:0] lim_w;
	logic signed [VEL_WIDTH:0] neg_lim_w;
	logic signed [VEL_WIDTH:0] cur_w;
	logic signed [VEL_WIDTH:0] diff_w;
	logic signed [VEL_WIDTH:0] step_w;
	logic signed [VEL_WIDTH:0] neg_step_w;
	logic signed [VEL_WIDTH:0] up_w;
	logic signed [VEL_WIDTH:0] down_w;
	logic                      near;

	assign cmd_w      = {cmd[VEL_WIDTH-1], cmd};
	assign lim_w      = signed'({2'b00, limit});
	assign neg_lim_w  = -lim_w;
	assign cur_w      = {cur[VEL_WIDTH-1], cur};
	assign diff_w     = {tgt[VEL_WIDTH-1], tgt} - cur_w;
	assign step_w     = signed'({2'b00, step});
	assign neg_step_w = -step_w;
	assign up_w       = cur_w + step_w;
	assign down_w     = cur_w - step_w;
	assign near       = (diff_w <= step_w) && (diff_w >= neg_step_w);

	always_comb begin
		res.over    = 1'b0;
		res.clamped = cmd;
		if (cmd_w > lim_w) begin
			res.over    = 1'b1;
			res.clamped = lim_w[VEL_WIDTH-1:0];
		end else if (cmd_w < neg_lim_w) begin
			res.over    = 1'b1;
			res.clamped = neg_lim_w[VEL_WIDTH-1:0];
		end

		// zero step jumps straight to the target
		if (step == '0 || near) begin
			res.next = tgt;
		end else if (diff_w > 0) begin
			res.next = up_w[VEL_WIDTH-1:0];
		end else begin
			res.next = down_w[VEL_WIDTH-1:0];
		end
	end

endmodule
